[rtl/core/crcfr_pkg.sv]
package crcfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W = 16;
    localparam int unsigned CRC_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned STATUS_W = 3;

    // Longest payload accepted for a log frame.
    localparam int unsigned MAX_LOG_LENGTH = 255;
    localparam logic [LEN_W-1:0] LOG_LEN_MAX = LEN_W'(MAX_LOG_LENGTH);
    localparam logic [LEN_W-1:0] TELEMETRY_LEN = LEN_W'(15);
    localparam logic [LEN_W-1:0] COMMAND_LEN = LEN_W'(7);

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREFIX_FIRST  = 3'd0,
        CFG_PREFIX_SECOND = 3'd1,
        CFG_VERSION_CODE  = 3'd2,
        CFG_TELEMETRY     = 3'd3,
        CFG_COMMAND       = 3'd4,
        CFG_LOG           = 3'd5,
        CFG_PING          = 3'd6,
        CFG_PONG          = 3'd7
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_VERSION = 3'd1,
        ST_TYPE    = 3'd2,
        ST_LENGTH  = 3'd3,
        ST_CRC     = 3'd4
    } status_t;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] prefix_first;
        logic [BYTE_W-1:0] prefix_second;
        logic [BYTE_W-1:0] version_code;
        logic [BYTE_W-1:0] telemetry_code;
        logic [BYTE_W-1:0] command_code;
        logic [BYTE_W-1:0] log_code;
        logic [BYTE_W-1:0] ping_code;
        logic [BYTE_W-1:0] pong_code;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [BYTE_W-1:0]  byte_index;
        logic [BYTE_W-1:0]  frame_type;
        status_t            frame_status;
    } res_t;

endpackage

[rtl/core/crcfr_if.sv]
interface crcfr_in_if;
    import crcfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfr_out_if;
    import crcfr_pkg::*;

    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [BYTE_W-1:0]   byte_index;
    logic [BYTE_W-1:0]   frame_type;
    logic [STATUS_W-1:0] frame_status;

    modport source (
        output valid, output result_kind, output data_byte, output byte_index,
        output frame_type, output frame_status, input ready
    );
    modport sink (
        input valid, input result_kind, input data_byte, input byte_index,
        input frame_type, input frame_status, output ready
    );
endinterface

[rtl/core/crcfr_crc8.sv]
module crcfr_crc8
    import crcfr_pkg::*;
(
    input  logic [CRC_W-1:0]  crc_in,
    input  logic [BYTE_W-1:0] data,
    output logic [CRC_W-1:0]  crc_out
);

    // Reflected CRC-16 update over one byte, least significant bit first.
    always_comb
    begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

[rtl/core/crcfr_cfg_regs.sv]
module crcfr_cfg_regs
    import crcfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PREFIX_FIRST:  cfg_next.prefix_first = cfg_data;
                CFG_PREFIX_SECOND: cfg_next.prefix_second = cfg_data;
                CFG_VERSION_CODE:  cfg_next.version_code = cfg_data;
                CFG_TELEMETRY:     cfg_next.telemetry_code = cfg_data;
                CFG_COMMAND:       cfg_next.command_code = cfg_data;
                CFG_LOG:           cfg_next.log_code = cfg_data;
                CFG_PING:          cfg_next.ping_code = cfg_data;
                CFG_PONG:          cfg_next.pong_code = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prefix_first <= 8'hAA;
            cfg_reg.prefix_second <= 8'h55;
            cfg_reg.version_code <= 8'h01;
            cfg_reg.telemetry_code <= 8'h00;
            cfg_reg.command_code <= 8'h01;
            cfg_reg.log_code <= 8'h02;
            cfg_reg.ping_code <= 8'h03;
            cfg_reg.pong_code <= 8'h04;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/crcfr_parser.sv]
module crcfr_parser
    import crcfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res
);

    typedef enum logic [8:0] {
        PH_HUNT0 = 9'b000000001,
        PH_HUNT1 = 9'b000000010,
        PH_VER   = 9'b000000100,
        PH_TYPE  = 9'b000001000,
        PH_LENLO = 9'b000010000,
        PH_LENHI = 9'b000100000,
        PH_DATA  = 9'b001000000,
        PH_CRCLO = 9'b010000000,
        PH_CRCHI = 9'b100000000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  done_reg, done_next;
    logic [BYTE_W-1:0] crc_lo_reg, crc_lo_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              byte_valid_reg, byte_valid_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    logic              stall;
    logic              take;
    logic              emit;
    logic [CRC_W-1:0]  crc_upd;
    logic              type_known;
    logic              len_ok;
    logic [LEN_W-1:0]  len_full;
    logic [LEN_W-1:0]  done_inc;

    crcfr_crc8 u_crc (
        .crc_in  (crc_reg),
        .data    (byte_reg),
        .crc_out (crc_upd)
    );

    // The held result blocks the byte in the input register only while it is not taken.
    assign stall = res_valid_reg && !res_ready;
    assign take = byte_valid_reg && !stall;
    assign in_ready = !byte_valid_reg || !stall;
    assign byte_valid_next = in_valid ? 1'b1 : (byte_valid_reg && stall);

    assign type_known = (byte_reg == cfg.telemetry_code) || (byte_reg == cfg.command_code)
                     || (byte_reg == cfg.log_code) || (byte_reg == cfg.ping_code)
                     || (byte_reg == cfg.pong_code);

    assign len_full = {byte_reg, len_reg[BYTE_W-1:0]};
    assign done_inc = done_reg + LEN_W'(1);

    // The first matching type code decides the length rule.
    always_comb
    begin
        priority if (type_reg == cfg.telemetry_code)
            len_ok = (len_full == TELEMETRY_LEN);
        else if (type_reg == cfg.command_code)
            len_ok = (len_full == COMMAND_LEN);
        else if (type_reg == cfg.log_code)
            len_ok = (len_full <= LOG_LEN_MAX);
        else if ((type_reg == cfg.ping_code) || (type_reg == cfg.pong_code))
            len_ok = (len_full == '0);
        else
            len_ok = 1'b0;
    end

    always_comb
    begin
        phase_next = phase_reg;
        crc_next = crc_reg;
        type_next = type_reg;
        len_next = len_reg;
        done_next = done_reg;
        crc_lo_next = crc_lo_reg;
        emit = 1'b0;
        res_next = res_reg;

        if (take)
        begin
            res_next = '0;
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (byte_reg == cfg.prefix_second)
                    begin
                        phase_next = PH_VER;
                        crc_next = CRC_INIT;
                        type_next = '0;
                        len_next = '0;
                        done_next = '0;
                        crc_lo_next = '0;
                    end
                    else if (byte_reg != cfg.prefix_first)
                    begin
                        phase_next = PH_HUNT0;
                    end
                end
                PH_VER:
                begin
                    if (byte_reg != cfg.version_code)
                    begin
                        emit = 1'b1;
                        res_next.kind = KIND_END;
                        res_next.frame_status = ST_VERSION;
                        phase_next = PH_HUNT0;
                    end
                    else
                    begin
                        crc_next = crc_upd;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next = byte_reg;
                    if (!type_known)
                    begin
                        emit = 1'b1;
                        res_next.kind = KIND_END;
                        res_next.frame_type = byte_reg;
                        res_next.frame_status = ST_TYPE;
                        phase_next = PH_HUNT0;
                    end
                    else
                    begin
                        crc_next = crc_upd;
                        phase_next = PH_LENLO;
                    end
                end
                PH_LENLO:
                begin
                    len_next = {{(LEN_W-BYTE_W){1'b0}}, byte_reg};
                    crc_next = crc_upd;
                    phase_next = PH_LENHI;
                end
                PH_LENHI:
                begin
                    len_next = len_full;
                    if (!len_ok)
                    begin
                        emit = 1'b1;
                        res_next.kind = KIND_END;
                        res_next.frame_type = type_reg;
                        res_next.frame_status = ST_LENGTH;
                        phase_next = PH_HUNT0;
                    end
                    else
                    begin
                        crc_next = crc_upd;
                        done_next = '0;
                        phase_next = (len_full == '0) ? PH_CRCLO : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    crc_next = crc_upd;
                    emit = 1'b1;
                    res_next.kind = KIND_DATA;
                    res_next.data_byte = byte_reg;
                    res_next.byte_index = done_reg[BYTE_W-1:0];
                    res_next.frame_type = type_reg;
                    res_next.frame_status = ST_OK;
                    done_next = done_inc;
                    if (done_inc >= len_reg)
                    begin
                        phase_next = PH_CRCLO;
                    end
                end
                PH_CRCLO:
                begin
                    crc_lo_next = byte_reg;
                    phase_next = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    emit = 1'b1;
                    res_next.kind = KIND_END;
                    res_next.frame_type = type_reg;
                    res_next.frame_status = ({byte_reg, crc_lo_reg} == crc_reg) ? ST_OK : ST_CRC;
                    phase_next = PH_HUNT0;
                end
                default:
                begin
                    phase_next = (byte_reg == cfg.prefix_first) ? PH_HUNT1 : PH_HUNT0;
                end
            endcase
        end

        res_valid_next = take ? emit : stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT0;
            crc_reg <= CRC_INIT;
            type_reg <= '0;
            len_reg <= '0;
            done_reg <= '0;
            crc_lo_reg <= '0;
            byte_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            crc_reg <= crc_next;
            type_reg <= type_next;
            len_reg <= len_next;
            done_reg <= done_next;
            crc_lo_reg <= crc_lo_next;
            byte_valid_reg <= byte_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

endmodule

[rtl/core/crc16_frame_receiver_core.sv]
// Byte-stream frame receiver with a CRC-16/MODBUS check. One received byte is accepted per
// clock cycle as long as results are taken; a byte lands in an input register and is parsed
// from there, so each payload byte or end-of-frame result is registered and held until it is
// taken. Throughput is bound by the byte-wise CRC update and state step. The receiver hunts
// for the two prefix bytes, checks version, type and little-endian length, passes payload bytes
// out with their index, and closes each frame (or any error) with one end result carrying the
// status. Configuration registers are to be written by the user through the plain write port
// only while no byte is in flight; the block itself does not enforce this.
module crc16_frame_receiver_core
    import crcfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    crcfr_in_if.sink             rx,
    crcfr_out_if.source          res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    cfg_t cfg;
    res_t res_data;

    crcfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crcfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .in_byte   (rx.rx_byte),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .res       (res_data)
    );

    assign res.result_kind = res_data.kind;
    assign res.data_byte = res_data.data_byte;
    assign res.byte_index = res_data.byte_index;
    assign res.frame_type = res_data.frame_type;
    assign res.frame_status = res_data.frame_status;

endmodule
